>>> design/lfg_pkg.sv
package lfg_pkg;

   localparam int DSQ_W = 22;
   localparam logic [DSQ_W-1:0] NEVER_REACHED = {DSQ_W{1'b1}};
   localparam logic [DSQ_W-1:0] DSQ_LIMIT = {{(DSQ_W-1){1'b1}}, 1'b0};
   localparam int GAIN_W = 24;
   localparam int GAIN_FRAC = 16;
   localparam int TAB_FRAC = 6;
   localparam int POS_W = 14;
   localparam int OP_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [63:0] EXP_STEP_Q32 = 64'd4228380001;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_REACH  = 2'd2,
      CSR_GAIN   = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_ADD_RD,
      ST_ADD_WAIT,
      ST_ADD_WR,
      ST_Q_RD,
      ST_Q_WAIT,
      ST_Q_MUL,
      ST_Q_TAB,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic clr_start;
      logic clr_step;
      logic add_start;
      logic mem_rd;
      logic add_wr;
      logic add_next;
      logic q_rd;
      logic q_mul;
      logic q_tab;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic add_empty;
      logic add_last;
   } sts_type;

   // exp table built at elaboration
   function automatic logic [7:0] exp_entry(input int k);
      logic [63:0] e;
      logic [63:0] v;
      e = 64'h1_0000_0000;
      for (int i = 0; i < k; i++)
         e = (e * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
      v = (64'd255 * e + 64'h8000_0000) >> 32;
      return v[7:0];
   endfunction

endpackage

>>> design/lfg_ctrl.sv
module lfg_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_op,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  lfg_pkg::sts_type  sts,
   output lfg_pkg::cmd_type  cmd
);

   lfg_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;
   logic done;

   assign req_stall = (state_ff != lfg_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign done = (state_ff == lfg_pkg::ST_OUT);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lfg_pkg::ST_INIT: if (sts.clr_last) state_in = lfg_pkg::ST_IDLE;
         lfg_pkg::ST_IDLE: begin
            if (accept) begin
               case (lfg_pkg::op_type'(req_op))
                  lfg_pkg::OP_CLEAR: state_in = lfg_pkg::ST_CLEAR;
                  lfg_pkg::OP_ADD:   state_in = lfg_pkg::ST_ADD_RD;
                  lfg_pkg::OP_QUERY: state_in = lfg_pkg::ST_Q_RD;
                  default:           state_in = lfg_pkg::ST_OUT;
               endcase
            end
         end
         lfg_pkg::ST_CLEAR: if (sts.clr_last) state_in = lfg_pkg::ST_OUT;
         lfg_pkg::ST_ADD_RD: begin
            if (sts.add_empty) state_in = lfg_pkg::ST_OUT;
            else state_in = lfg_pkg::ST_ADD_WAIT;
         end
         lfg_pkg::ST_ADD_WAIT: state_in = lfg_pkg::ST_ADD_WR;
         lfg_pkg::ST_ADD_WR: begin
            if (sts.add_last) state_in = lfg_pkg::ST_OUT;
            else state_in = lfg_pkg::ST_ADD_RD;
         end
         lfg_pkg::ST_Q_RD:   state_in = lfg_pkg::ST_Q_WAIT;
         lfg_pkg::ST_Q_WAIT: state_in = lfg_pkg::ST_Q_MUL;
         lfg_pkg::ST_Q_MUL:  state_in = lfg_pkg::ST_Q_TAB;
         lfg_pkg::ST_Q_TAB:  state_in = lfg_pkg::ST_OUT;
         lfg_pkg::ST_OUT:    state_in = lfg_pkg::ST_IDLE;
         default:            state_in = lfg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.load = accept;
      case (state_ff)
         lfg_pkg::ST_IDLE: begin
            cmd.clr_start = accept && (req_op == lfg_pkg::OP_CLEAR);
            cmd.add_start = accept && (req_op == lfg_pkg::OP_ADD);
         end
         lfg_pkg::ST_INIT, lfg_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
         lfg_pkg::ST_ADD_RD:   cmd.mem_rd = !sts.add_empty;
         lfg_pkg::ST_ADD_WR: begin
            cmd.add_wr = 1'b1;
            cmd.add_next = 1'b1;
         end
         lfg_pkg::ST_Q_RD:  cmd.q_rd = 1'b1;
         lfg_pkg::ST_Q_MUL: cmd.q_mul = 1'b1;
         lfg_pkg::ST_Q_TAB: cmd.q_tab = 1'b1;
         lfg_pkg::ST_OUT:   cmd.out_load = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (done) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfg_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_out_needs_room: assert property (@(posedge clock) disable iff (reset)
      done |-> !(rsp_valid_ff && rsp_stall)) else $error("result overwritten");
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != lfg_pkg::ST_IDLE) |-> req_stall) else $error("accept while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid) else $error("result lost");

endmodule

>>> design/lfg_dp.sv
module lfg_dp #(
   parameter int GRID_MAX_WIDTH  = 256,
   parameter int GRID_MAX_HEIGHT = 256,
   parameter int FRAC_BITS       = 6,
   parameter int MAX_REACH       = 15,
   parameter int EXP_TABLE_DEPTH = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lfg_pkg::cmd_type               cmd,
   output lfg_pkg::sts_type               sts,
   input  logic [1:0]                     req_op,
   input  logic [lfg_pkg::POS_W-1:0]      req_pos_x,
   input  logic [lfg_pkg::POS_W-1:0]      req_pos_y,
   input  logic                           csr_write,
   input  logic [lfg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lfg_pkg::CSR_DATA_W-1:0] csr_data,
   output logic [7:0]                     rsp_likelihood,
   output logic                           rsp_inside_grid
);

   localparam int XW = $clog2(GRID_MAX_WIDTH);
   localparam int YW = $clog2(GRID_MAX_HEIGHT);
   localparam int AW = XW + YW;
   localparam int DEPTH = GRID_MAX_WIDTH * GRID_MAX_HEIGHT;
   localparam int CW = lfg_pkg::POS_W - FRAC_BITS;
   localparam int RW = $clog2(MAX_REACH + 1);
   localparam int TW = $clog2(EXP_TABLE_DEPTH);
   localparam int SHIFT = lfg_pkg::GAIN_FRAC + 2 * FRAC_BITS - lfg_pkg::TAB_FRAC;
   localparam int PW = lfg_pkg::GAIN_W + lfg_pkg::DSQ_W;
   localparam int DW = lfg_pkg::POS_W + 1;
   localparam int SW = 2 * DW + 1;
   localparam int EW = (XW > CW ? XW : CW) + 2;

   logic [lfg_pkg::DSQ_W-1:0] mem [DEPTH];
   logic [lfg_pkg::DSQ_W-1:0] rd_ff;
   logic [7:0] exp_tab [EXP_TABLE_DEPTH];

   for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_tab
      assign exp_tab[k] = lfg_pkg::exp_entry(k);
   end

   logic [8:0] width_ff, height_ff;
   logic [3:0] reach_ff;
   logic [lfg_pkg::GAIN_W-1:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 9'd256;
         height_ff <= 9'd256;
         reach_ff <= 4'd5;
         gain_ff <= 24'd2048;
      end else if (csr_write) begin
         case (lfg_pkg::csr_idx_type'(csr_index))
            lfg_pkg::CSR_WIDTH:  width_ff <= csr_data[8:0];
            lfg_pkg::CSR_HEIGHT: height_ff <= csr_data[8:0];
            lfg_pkg::CSR_REACH:  reach_ff <= csr_data[3:0];
            lfg_pkg::CSR_GAIN:   gain_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic [EW-1:0] w_eff, h_eff, r_eff;
   assign w_eff = (EW'(width_ff) > EW'(GRID_MAX_WIDTH)) ? EW'(GRID_MAX_WIDTH) : EW'(width_ff);
   assign h_eff = (EW'(height_ff) > EW'(GRID_MAX_HEIGHT)) ? EW'(GRID_MAX_HEIGHT)
                                                          : EW'(height_ff);
   assign r_eff = (EW'(reach_ff) > EW'(MAX_REACH)) ? EW'(MAX_REACH) : EW'(reach_ff);

   logic [lfg_pkg::POS_W-1:0] px_ff, py_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff <= req_pos_x;
         py_ff <= req_pos_y;
      end
   end

   logic [EW-1:0] ox, oy;
   assign ox = EW'(px_ff[lfg_pkg::POS_W-1:FRAC_BITS]);
   assign oy = EW'(py_ff[lfg_pkg::POS_W-1:FRAC_BITS]);

   // clear sweep
   logic [AW:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clr_start) clr_ff <= '0;
      else if (cmd.clr_step) clr_ff <= clr_ff + 1'b1;
   end
   assign sts.clr_last = (clr_ff == (AW+1)'(DEPTH - 1));

   // obstacle window scan
   logic [EW-1:0] x0_ff, x1_ff, y1_ff, gx_ff, gy_ff;
   logic empty_ff;
   logic [EW-1:0] nox, noy, nx0, ny0, nx1, ny1;
   assign nox = EW'(req_pos_x[lfg_pkg::POS_W-1:FRAC_BITS]);
   assign noy = EW'(req_pos_y[lfg_pkg::POS_W-1:FRAC_BITS]);
   assign nx0 = (nox > r_eff) ? nox - r_eff : '0;
   assign ny0 = (noy > r_eff) ? noy - r_eff : '0;
   assign nx1 = (nox + r_eff < w_eff - 1'b1) ? nox + r_eff : w_eff - 1'b1;
   assign ny1 = (noy + r_eff < h_eff - 1'b1) ? noy + r_eff : h_eff - 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.add_start) begin
         x0_ff <= nx0;
         x1_ff <= nx1;
         y1_ff <= ny1;
         gx_ff <= nx0;
         gy_ff <= ny0;
         empty_ff <= (w_eff == '0) || (h_eff == '0) || (nx0 > nx1) || (ny0 > ny1);
      end else if (cmd.add_next) begin
         if (gx_ff == x1_ff) begin
            gx_ff <= x0_ff;
            gy_ff <= gy_ff + 1'b1;
         end else begin
            gx_ff <= gx_ff + 1'b1;
         end
      end
   end
   assign sts.add_empty = empty_ff;
   assign sts.add_last = (gx_ff == x1_ff) && (gy_ff == y1_ff);

   // squared distance of current cell, registered
   logic [DW-1:0] cx, cy, dx, dy;
   logic [SW-1:0] dsum;
   logic [lfg_pkg::DSQ_W-1:0] dsq_ff;
   assign cx = (DW'(gx_ff) << FRAC_BITS) + DW'(1 << (FRAC_BITS - 1));
   assign cy = (DW'(gy_ff) << FRAC_BITS) + DW'(1 << (FRAC_BITS - 1));
   assign dx = (cx > DW'(px_ff)) ? cx - DW'(px_ff) : DW'(px_ff) - cx;
   assign dy = (cy > DW'(py_ff)) ? cy - DW'(py_ff) : DW'(py_ff) - cy;
   assign dsum = SW'(dx * dx) + SW'(dy * dy);
   always_ff @(posedge clock) begin
      if (cmd.mem_rd)
         dsq_ff <= (dsum > SW'(lfg_pkg::DSQ_LIMIT)) ? lfg_pkg::DSQ_LIMIT
                                                   : dsum[lfg_pkg::DSQ_W-1:0];
   end

   logic [AW-1:0] cell_addr, q_addr;
   assign cell_addr = {gy_ff[YW-1:0], gx_ff[XW-1:0]};
   assign q_addr = {oy[YW-1:0], ox[XW-1:0]};

   logic q_in_grid;
   assign q_in_grid = (ox < w_eff) && (oy < h_eff);

   logic [AW-1:0] rd_addr;
   assign rd_addr = cmd.q_rd ? q_addr : cell_addr;

   always_ff @(posedge clock) begin
      if (cmd.clr_step)
         mem[clr_ff[AW-1:0]] <= lfg_pkg::NEVER_REACHED;
      else if (cmd.add_wr && (dsq_ff < rd_ff))
         mem[cell_addr] <= dsq_ff;
   end
   always_ff @(posedge clock) begin
      if (cmd.mem_rd || cmd.q_rd) rd_ff <= mem[rd_addr];
   end

   // query
   logic inside_ff;
   logic [PW-1:0] prod_ff;
   logic reached_ff;
   logic [7:0] lik_ff;
   always_ff @(posedge clock) begin
      if (cmd.q_rd) inside_ff <= q_in_grid;
      if (cmd.q_mul) begin
         prod_ff <= PW'(gain_ff) * PW'(rd_ff);
         reached_ff <= (rd_ff != lfg_pkg::NEVER_REACHED);
      end
      if (cmd.q_tab) begin
         if (inside_ff && reached_ff && ((prod_ff >> SHIFT) < PW'(EXP_TABLE_DEPTH)))
            lik_ff <= exp_tab[prod_ff[SHIFT +: TW]];
         else
            lik_ff <= 8'd0;
      end
   end

   logic [7:0] out_lik_ff;
   logic out_in_ff;
   logic is_query_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) is_query_ff <= (req_op == lfg_pkg::OP_QUERY);
      if (cmd.out_load) begin
         out_lik_ff <= is_query_ff ? lik_ff : 8'd0;
         out_in_ff <= is_query_ff & inside_ff;
      end
   end
   assign rsp_likelihood = out_lik_ff;
   assign rsp_inside_grid = out_in_ff;

   a_write_in_window: assert property (@(posedge clock) disable iff (reset)
      cmd.add_wr |-> (gx_ff < w_eff) && (gy_ff < h_eff)) else $error("write off grid");
   a_no_dual_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clr_step && cmd.add_wr)) else $error("write conflict");
   a_min_only: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_rd |=> !cmd.add_wr) else $error("write before read data");

endmodule

>>> design/likelihood_field_grid_unit.sv
// channel | direction | ports
// req     | in        | req_valid, req_stall, req_op, req_pos_x, req_pos_y
// rsp     | out       | rsp_valid, rsp_stall, rsp_likelihood, rsp_inside_grid
// csr     | in        | csr_write, csr_index, csr_data
// clear: writes every cell of the GRID_MAX_WIDTH*GRID_MAX_HEIGHT grid, one cell a cycle
// add: each window cell, up to 31x31, takes a read, a wait and a write on one memory port
// query: states Q_RD, Q_WAIT, Q_MUL, Q_TAB, then OUT; unused op goes straight to OUT
// reset starts a clearing pass over all GRID_MAX_WIDTH*GRID_MAX_HEIGHT cells, input stalled
// one transaction in flight; a new one waits until the result register can take it
module likelihood_field_grid_unit #(
   parameter int GRID_MAX_WIDTH  = 256,
   parameter int GRID_MAX_HEIGHT = 256,
   parameter int FRAC_BITS       = 6,
   parameter int MAX_REACH       = 15,
   parameter int EXP_TABLE_DEPTH = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_op,
   input  logic [lfg_pkg::POS_W-1:0]      req_pos_x,
   input  logic [lfg_pkg::POS_W-1:0]      req_pos_y,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_likelihood,
   output logic                           rsp_inside_grid,
   input  logic                           csr_write,
   input  logic [lfg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lfg_pkg::CSR_DATA_W-1:0] csr_data
);

   lfg_pkg::cmd_type cmd;
   lfg_pkg::sts_type sts;

   lfg_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_op,
      .rsp_valid, .rsp_stall, .sts, .cmd
   );

   lfg_dp #(
      .GRID_MAX_WIDTH(GRID_MAX_WIDTH), .GRID_MAX_HEIGHT(GRID_MAX_HEIGHT),
      .FRAC_BITS(FRAC_BITS), .MAX_REACH(MAX_REACH), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
   ) u_dp (
      .clock, .reset, .cmd, .sts, .req_op, .req_pos_x, .req_pos_y,
      .csr_write, .csr_index, .csr_data, .rsp_likelihood, .rsp_inside_grid
   );

endmodule
